// ===== rtl/core/fdsp_pkg.sv =====
// Shared types and constants of the four-neighbour despeckle filter.
`default_nettype none

package fdsp_pkg;

  // Pixel and register field widths are fixed by the stream and register formats.
  localparam int PIXEL_BITS      = 8;
  localparam int THR_BITS        = 8;
  localparam int SUM_BITS        = PIXEL_BITS + 2;
  localparam int WIDTH_REG_BITS  = 6;
  localparam int HEIGHT_REG_BITS = 11;
  localparam int CFG_IDX_BITS    = 2;
  localparam int CFG_DATA_BITS   = 11;

  typedef logic [PIXEL_BITS-1:0]   pix_t;
  typedef logic [CFG_IDX_BITS-1:0] cfg_idx_t;
  typedef logic [THR_BITS-1:0]     thr_t;

  localparam cfg_idx_t REG_IMAGE_WIDTH    = cfg_idx_t'(0);
  localparam cfg_idx_t REG_IMAGE_HEIGHT   = cfg_idx_t'(1);
  localparam cfg_idx_t REG_DIFF_THRESHOLD = cfg_idx_t'(2);

  // The center pixel and its four candidate neighbours.
  typedef struct packed {
    pix_t center;
    pix_t up;
    pix_t down;
    pix_t left;
    pix_t right;
  } nbr_t;

  // Where the filtered pixel sits in the frame.
  typedef struct packed {
    logic top;
    logic bottom;
    logic lcol;
    logic rcol;
  } pos_t;

endpackage

`default_nettype wire

// ===== rtl/core/fdsp_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module fdsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== rtl/core/fdsp_filt.sv =====
// Despeckle decision and neighbour average, split by one register stage.
`default_nettype none

module fdsp_filt (
  input  wire logic           clk_i,
  input  wire logic           load_i,
  input  wire fdsp_pkg::nbr_t nbr_i,
  input  wire fdsp_pkg::pos_t pos_i,
  input  wire fdsp_pkg::thr_t thresh_i,
  output      fdsp_pkg::pix_t pix_o
);

  import fdsp_pkg::*;

  // Division by three as a multiply by a rounded-up reciprocal; exact for any
  // dividend below 2**SUM_BITS because the shift is one bit wider than that.
  localparam int DIV3_SHIFT = SUM_BITS + 1;
  localparam int DIV3_MULT  = ((1 << DIV3_SHIFT) + 2) / 3;
  localparam int PROD_BITS  = SUM_BITS + DIV3_SHIFT;

  logic                  corner;
  logic                  use_u, use_d, use_l, use_r;
  logic                  far_u, far_d, far_l, far_r;
  logic                  all_far;
  logic [SUM_BITS-1:0]   sum;
  logic                  keep_q;
  logic                  four_q;
  pix_t                  center_q;
  logic [SUM_BITS-1:0]   sum_q;
  logic [SUM_BITS-1:0]   sum_round;
  logic [SUM_BITS-1:0]   sum_plus1;
  logic [PROD_BITS-1:0]  prod;

  function automatic logic far_from(pix_t a, pix_t b, thr_t thr);
    pix_t d;
    d = (a > b) ? (a - b) : (b - a);
    return d > thr;
  endfunction

  // An edge pixel drops the one neighbour that lies outside the frame.
  assign corner = (pos_i.top | pos_i.bottom) & (pos_i.lcol | pos_i.rcol);
  assign use_u  = ~pos_i.top;
  assign use_d  = ~pos_i.bottom;
  assign use_l  = ~pos_i.lcol;
  assign use_r  = ~pos_i.rcol;

  assign far_u = far_from(nbr_i.center, nbr_i.up, thresh_i);
  assign far_d = far_from(nbr_i.center, nbr_i.down, thresh_i);
  assign far_l = far_from(nbr_i.center, nbr_i.left, thresh_i);
  assign far_r = far_from(nbr_i.center, nbr_i.right, thresh_i);

  assign all_far = (far_u | ~use_u) & (far_d | ~use_d) & (far_l | ~use_l) & (far_r | ~use_r);

  assign sum = (use_u ? SUM_BITS'(nbr_i.up)    : '0)
             + (use_d ? SUM_BITS'(nbr_i.down)  : '0)
             + (use_l ? SUM_BITS'(nbr_i.left)  : '0)
             + (use_r ? SUM_BITS'(nbr_i.right) : '0);

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      keep_q   <= corner | ~all_far;
      four_q   <= use_u & use_d & use_l & use_r;
      center_q <= nbr_i.center;
      sum_q    <= sum;
    end
  end

  // Four neighbours: (sum + 2) / 4. Three: (2 * sum + 3) / 6, which equals (sum + 1) / 3.
  assign sum_round = sum_q + SUM_BITS'(2);
  assign sum_plus1 = sum_q + SUM_BITS'(1);
  assign prod      = PROD_BITS'(sum_plus1) * PROD_BITS'(DIV3_MULT);

  always_comb begin
    priority if (keep_q) begin
      pix_o = center_q;
    end else if (four_q) begin
      pix_o = sum_round[2 +: PIXEL_BITS];
    end else begin
      pix_o = prod[DIV3_SHIFT +: PIXEL_BITS];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/four_neighbour_despeckle_filter_top.sv =====
// Top level of the four-neighbour despeckle filter: control, row stores and stream ports.
`default_nettype none

// The block takes the pixels of one frame in raster order and emits them corrected, one row
// late. A pixel that differs by more than diff_threshold from every neighbour it has (four
// inside the frame, three on an edge, corners pass as they are) is replaced by the neighbour
// average, rounded half up. Corrections are in place: the left and upper neighbours are
// already corrected, the right and lower ones are original. The pixels of the first row of a
// frame are only stored and give no output. Each later pixel gives one output for the pixel
// directly above it, and the last pixel of the frame also flushes the whole bottom row, with
// m_axis_tuser marking the final pixel and m_axis_tlast marking the last output of each input
// item. Timing: a first-row item is only accepted and stored; any other item steps through
// accept, read center and upper pixel, read right pixel, filter and write back, plus any
// waits of the output for m_axis_tready; the last item of a frame then repeats read center
// and upper pixel, read right pixel, filter and write back for each of the image_width
// flushed pixels, again plus any output waits. The sequence is set by the two reads of the
// original row store through its single read port, followed by the two filter stages. One
// item is processed at a time, so store accesses never overlap and no forwarding is needed.
// Writing image_width or image_height restarts the frame; diff_threshold takes effect at once.
// Registers are to be written only while the block is idle; the block itself does not enforce
// this. Both row stores start undefined after reset and need no clearing pass: every entry is
// written in a frame before it is used.
module four_neighbour_despeckle_filter_top #(
  parameter int MAX_WIDTH  = 32,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Input stream. tdata: pixel_in [7:0].
  input  wire logic                                s_axis_tvalid,
  output      logic                                s_axis_tready,
  input  wire logic [7:0]                          s_axis_tdata,
  // Output stream. tdata: pixel_out [7:0]; tlast: last_of_run; tuser: frame_done.
  output      logic                                m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  output      logic [7:0]                          m_axis_tdata,
  output      logic                                m_axis_tlast,
  output      logic                                m_axis_tuser,
  // Register write port.
  input  wire logic                                cfg_we_i,
  input  wire fdsp_pkg::cfg_idx_t                  cfg_index_i,
  input  wire logic [fdsp_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i
);

  import fdsp_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);       // column index
  localparam int WW = $clog2(MAX_WIDTH + 1);   // column count
  localparam int RW = $clog2(MAX_HEIGHT);      // row index
  localparam int HW = $clog2(MAX_HEIGHT + 1);  // row count

  localparam logic [1:0] ST_IDLE = 2'd0;  // waiting for an item
  localparam logic [1:0] ST_CTR  = 2'd1;  // center and upper pixel arrive
  localparam logic [1:0] ST_RGT  = 2'd2;  // right pixel arrives, filter loads
  localparam logic [1:0] ST_OUT  = 2'd3;  // result out, stores written

  // Registers.
  logic [1:0]                 state_q, state_d;
  logic [WIDTH_REG_BITS-1:0]  width_q;
  logic [HEIGHT_REG_BITS-1:0] height_q;
  thr_t                       thresh_q;
  logic [RW-1:0]              row_q;
  logic [CW-1:0]              col_q;
  logic [CW-1:0]              j_q;
  pix_t                       left_q;
  logic                       flush_q;
  logic                       last_q;
  logic                       top_q;
  pix_t                       p_q;
  pix_t                       center_q;
  pix_t                       up_q;
  logic                       out_valid_q;
  pix_t                       out_pix_q;
  logic                       out_last_q;
  logic                       out_done_q;

  // Effective sizes and control.
  logic [WW-1:0]              eff_w, w_m1, j_inc_w;
  logic [HW-1:0]              eff_h, h_m1;
  logic [CW-1:0]              j_inc;
  logic                       in_acc, out_acc, go;
  logic                       row_zero, at_last_in, job_last, right_ok;

  // Store ports.
  logic                       orig_we;
  logic [CW-1:0]              orig_waddr, orig_raddr, rd_addr;
  pix_t                       orig_wdata, orig_rdata, corr_rdata;
  pix_t                       filt_pix;
  nbr_t                       nbr;
  pos_t                       pos;

  // Size registers are clamped to the range the stores and counters support.
  always_comb begin
    priority if (width_q < WIDTH_REG_BITS'(3)) begin
      eff_w = WW'(3);
    end else if (int'(width_q) > MAX_WIDTH) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(width_q);
    end
    priority if (height_q < HEIGHT_REG_BITS'(3)) begin
      eff_h = HW'(3);
    end else if (int'(height_q) > MAX_HEIGHT) begin
      eff_h = HW'(MAX_HEIGHT);
    end else begin
      eff_h = HW'(height_q);
    end
  end

  assign w_m1    = eff_w - WW'(1);
  assign h_m1    = eff_h - HW'(1);
  assign j_inc   = j_q + CW'(1);
  assign j_inc_w = WW'(j_q) + WW'(1);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_acc       = out_valid_q & m_axis_tready;
  assign go            = (state_q == ST_OUT) & (~out_valid_q | m_axis_tready);

  assign row_zero   = (row_q == '0);
  assign at_last_in = (HW'(row_q) == h_m1) & (WW'(col_q) == w_m1);
  assign job_last   = flush_q & (WW'(j_q) == w_m1);
  assign right_ok   = (j_inc_w < eff_w);

  // The read address runs one step ahead of the FSM: in the accept cycle and in the
  // write-back cycle it already points at the next pixel to filter.
  always_comb begin
    unique case (state_q)
      ST_IDLE: rd_addr = col_q;
      ST_OUT:  rd_addr = flush_q ? j_inc : '0;
      default: rd_addr = j_q;
    endcase
  end

  assign orig_raddr = (state_q == ST_CTR) ? j_inc : rd_addr;

  // The original pixel of a later row replaces its slot only once the slot has been read.
  assign orig_we    = (in_acc & row_zero) | (go & ~flush_q);
  assign orig_waddr = (state_q == ST_IDLE) ? col_q : j_q;
  assign orig_wdata = (state_q == ST_IDLE) ? s_axis_tdata : p_q;

  fdsp_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_orig_ram (
    .clk_i   (clk_i),
    .we_i    (orig_we),
    .waddr_i (orig_waddr),
    .wdata_i (orig_wdata),
    .raddr_i (orig_raddr),
    .rdata_o (orig_rdata)
  );

  fdsp_ram #(
    .WIDTH (PIXEL_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_corr_ram (
    .clk_i   (clk_i),
    .we_i    (go),
    .waddr_i (j_q),
    .wdata_i (filt_pix),
    .raddr_i (rd_addr),
    .rdata_o (corr_rdata)
  );

  // During the flush the row below lies outside the frame.
  always_comb begin
    nbr.center = center_q;
    nbr.up     = up_q;
    nbr.down   = flush_q ? '0 : p_q;
    nbr.left   = left_q;
    nbr.right  = right_ok ? orig_rdata : '0;
    pos.top    = top_q;
    pos.bottom = flush_q;
    pos.lcol   = (j_q == '0);
    pos.rcol   = (WW'(j_q) == w_m1);
  end

  fdsp_filt u_filt (
    .clk_i    (clk_i),
    .load_i   (state_q == ST_RGT),
    .nbr_i    (nbr),
    .pos_i    (pos),
    .thresh_i (thresh_q),
    .pix_o    (filt_pix)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && !row_zero) begin
          state_d = ST_CTR;
        end
      end
      ST_CTR: state_d = ST_RGT;
      ST_RGT: state_d = ST_OUT;
      ST_OUT: begin
        if (go) begin
          state_d = ((flush_q && !job_last) || (!flush_q && last_q)) ? ST_CTR : ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WIDTH_REG_BITS'(30);
      height_q    <= HEIGHT_REG_BITS'(20);
      thresh_q    <= THR_BITS'(1);
      row_q       <= '0;
      col_q       <= '0;
      j_q         <= '0;
      left_q      <= '0;
      flush_q     <= 1'b0;
      last_q      <= 1'b0;
      top_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (in_acc) begin
        j_q     <= col_q;
        top_q   <= (row_q == RW'(1));
        last_q  <= at_last_in;
        flush_q <= 1'b0;
        if (at_last_in) begin
          row_q <= '0;
          col_q <= '0;
        end else if (WW'(col_q) == w_m1) begin
          col_q <= '0;
          row_q <= row_q + RW'(1);
        end else begin
          col_q <= col_q + CW'(1);
        end
      end

      if (out_acc) begin
        out_valid_q <= 1'b0;
      end

      if (go) begin
        out_valid_q <= 1'b1;
        left_q      <= filt_pix;
        if (flush_q) begin
          if (job_last) begin
            flush_q <= 1'b0;
          end else begin
            j_q <= j_inc;
          end
        end else if (last_q) begin
          // The bottom row follows, starting at the left edge.
          flush_q <= 1'b1;
          top_q   <= 1'b0;
          j_q     <= '0;
          left_q  <= '0;
        end
      end

      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_IMAGE_WIDTH: begin
            width_q <= cfg_wdata_i[WIDTH_REG_BITS-1:0];
            row_q   <= '0;
            col_q   <= '0;
            left_q  <= '0;
          end
          REG_IMAGE_HEIGHT: begin
            height_q <= cfg_wdata_i[HEIGHT_REG_BITS-1:0];
            row_q    <= '0;
            col_q    <= '0;
            left_q   <= '0;
          end
          REG_DIFF_THRESHOLD: begin
            thresh_q <= cfg_wdata_i[THR_BITS-1:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Pixel data registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      p_q <= s_axis_tdata;
    end
    if (state_q == ST_CTR) begin
      center_q <= orig_rdata;
      up_q     <= corr_rdata;
    end
    if (go) begin
      out_pix_q  <= filt_pix;
      out_last_q <= flush_q ? job_last : ~last_q;
      out_done_q <= job_last;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_done_q;

`ifndef SYNTHESIS
  // A later-row item always starts the read sequence.
  a_row_item_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !row_zero) |=> (state_q == ST_CTR))
    else $error("later-row item did not start the store reads");

  // The frame-done output is also the last output of its input item.
  a_done_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser) |-> m_axis_tlast)
    else $error("frame_done without last_of_run");

  // The position counters stay inside the effective frame.
  a_pos_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (WW'(col_q) < eff_w) && (HW'(row_q) < eff_h))
    else $error("position counter outside the frame");

  // No new item is taken while the bottom row is being flushed.
  a_flush_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> !s_axis_tready)
    else $error("input taken during the flush");

  // Once the final pixel of a frame is produced, the next frame starts at its origin.
  a_frame_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (go && job_last) |=> (row_q == '0) && (col_q == '0))
    else $error("counters not at frame start after frame_done");
`endif

endmodule

`default_nettype wire
